// ----- design/mwm_pkg.sv -----
`timescale 1ns / 1ps
package mwm_pkg;

  localparam int MAP_WIDTH_DEF  = 16;
  localparam int MAP_HEIGHT_DEF = 16;

  localparam logic [7:0] WALL_N         = 8'h01;
  localparam logic [7:0] WALL_E         = 8'h02;
  localparam logic [7:0] WALL_S         = 8'h04;
  localparam logic [7:0] WALL_W         = 8'h08;
  localparam logic [7:0] FLAG_VISITED   = 8'h10;
  localparam logic [7:0] FLAG_CONFIRMED = 8'h20;

  localparam int VISITED_BIT   = 4;
  localparam int CONFIRMED_BIT = 5;

  typedef enum logic [2:0] {
    OP_QUERY   = 3'd0,
    OP_WALL    = 3'd1,
    OP_VISIT   = 3'd2,
    OP_CONFIRM = 3'd3,
    OP_RAW     = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_NREAD,
    ST_NWRITE,
    ST_DONE
  } state_t;

  // result word held between the sequencer and the output formatter
  typedef struct packed {
    logic       in_range;
    logic [1:0] dir;
    logic [7:0] cbyte;
  } res_t;

  function automatic logic [7:0] side_mask(input logic [1:0] dir);
    logic [7:0] m;
    case (dir)
      DIR_N:   m = WALL_N;
      DIR_E:   m = WALL_E;
      DIR_S:   m = WALL_S;
      default: m = WALL_W;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] facing_mask(input logic [1:0] dir);
    logic [7:0] m;
    case (dir)
      DIR_N:   m = WALL_S;
      DIR_E:   m = WALL_W;
      DIR_S:   m = WALL_N;
      default: m = WALL_E;
    endcase
    return m;
  endfunction

  // value of a cell right after a map clear
  function automatic logic [7:0] border_byte(input logic [7:0] x, input logic [7:0] y,
                                             input int w, input int h);
    logic [7:0] b;
    b = 8'h00;
    if (y == 8'd0) b = b | WALL_S;
    if (int'(y) == h - 1) b = b | WALL_N;
    if (x == 8'd0) b = b | WALL_W;
    if (int'(x) == w - 1) b = b | WALL_E;
    return b;
  endfunction

endpackage

// ----- design/mwm_in_if.sv -----
`timescale 1ns / 1ps
interface mwm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] cell_x;
  logic [7:0] cell_y;
  logic [1:0] direction;
  logic       wall_present;
  logic [7:0] raw_byte;

  modport source (output valid, op, cell_x, cell_y, direction, wall_present, raw_byte,
                  input ready);
  modport sink (input valid, op, cell_x, cell_y, direction, wall_present, raw_byte,
                output ready);
endinterface

// ----- design/mwm_out_if.sv -----
`timescale 1ns / 1ps
interface mwm_out_if;
  logic       valid;
  logic       ready;
  logic       cell_in_range;
  logic       has_wall;
  logic       is_visited;
  logic       is_confirmed;
  logic [7:0] cell_byte;

  modport source (output valid, cell_in_range, has_wall, is_visited, is_confirmed, cell_byte,
                  input ready);
  modport sink (input valid, cell_in_range, has_wall, is_visited, is_confirmed, cell_byte,
                output ready);
endinterface

// ----- design/mwm_ram.sv -----
`timescale 1ns / 1ps
module mwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- design/mwm_result.sv -----
`timescale 1ns / 1ps
module mwm_result (
  input  mwm_pkg::res_t res,
  output logic          cell_in_range,
  output logic          has_wall,
  output logic          is_visited,
  output logic          is_confirmed,
  output logic [7:0]    cell_byte
);

  // wall bits sit at bit positions equal to the direction code
  always_comb begin
    cell_in_range = res.in_range;
    has_wall      = res.in_range ? res.cbyte[res.dir] : 1'b1;
    is_visited    = res.in_range & res.cbyte[mwm_pkg::VISITED_BIT];
    is_confirmed  = res.in_range & res.cbyte[mwm_pkg::CONFIRMED_BIT];
    cell_byte     = res.in_range ? res.cbyte : 8'h00;
  end

endmodule

// ----- design/maze_wall_map_store_core.sv -----
`timescale 1ns / 1ps
// query, flag and raw writes: result registered in ST_CELL or ST_DONE; next request taken in ST_IDLE
// wall write with a neighbor: ST_CELL, ST_NREAD, ST_NWRITE, for the read-modify-write of two cells
// on the single-port cell memory
// clear map: writes all 2**(clog2(MAP_WIDTH)+clog2(MAP_HEIGHT)) rows, one memory row per cycle
// reset (synchronous, rst high) runs the same clearing pass over 256 rows at 16x16,
// with req.ready low until it ends
module maze_wall_map_store_core #(
  parameter int MAP_WIDTH  = mwm_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = mwm_pkg::MAP_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mwm_in_if.sink    req,
  mwm_out_if.source rsp
);

  localparam int XB    = $clog2(MAP_WIDTH);
  localparam int YB    = $clog2(MAP_HEIGHT);
  localparam int AW    = XB + YB;
  localparam int DEPTH = 1 << AW;

  mwm_pkg::state_t state, state_next;
  logic [AW-1:0]   clr_cnt;
  logic            clr_result;
  logic [2:0]      op_q;
  logic [XB-1:0]   x_q;
  logic [YB-1:0]   y_q;
  logic [1:0]      dir_q;
  logic            wp_q;
  logic [7:0]      raw_q;
  mwm_pkg::res_t   res;
  mwm_pkg::res_t   out_res;
  logic            out_valid;

  logic            accept;
  logic            req_in_range;
  logic            out_free;
  logic            load_out;
  mwm_pkg::res_t   load_res;
  mwm_pkg::res_t   res_cell;
  mwm_pkg::res_t   res_clear;
  logic [7:0]      new_byte;
  logic [7:0]      nb_byte;
  logic            nb_ok;
  logic [XB-1:0]   nb_x;
  logic [YB-1:0]   nb_y;
  logic            clr_last;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  assign accept       = req.valid && req.ready;
  assign req_in_range = (req.cell_x < 8'(MAP_WIDTH)) && (req.cell_y < 8'(MAP_HEIGHT));
  assign out_free     = !out_valid || rsp.ready;
  assign clr_last     = (clr_cnt == {AW{1'b1}});

  // neighbor cell across the written wall
  always_comb begin
    nb_x  = x_q;
    nb_y  = y_q;
    nb_ok = 1'b0;
    case (dir_q)
      mwm_pkg::DIR_N: begin
        nb_ok = ({24'd0, 8'(y_q)} + 32'd1) < 32'(MAP_HEIGHT);
        nb_y  = y_q + YB'(1);
      end
      mwm_pkg::DIR_E: begin
        nb_ok = ({24'd0, 8'(x_q)} + 32'd1) < 32'(MAP_WIDTH);
        nb_x  = x_q + XB'(1);
      end
      mwm_pkg::DIR_S: begin
        nb_ok = (y_q != '0);
        nb_y  = y_q - YB'(1);
      end
      default: begin
        nb_ok = (x_q != '0);
        nb_x  = x_q - XB'(1);
      end
    endcase
  end

  // modify step on the named cell
  always_comb begin
    case (op_q)
      mwm_pkg::OP_WALL:
        new_byte = wp_q ? (ram_rdata | mwm_pkg::side_mask(dir_q))
                        : (ram_rdata & ~mwm_pkg::side_mask(dir_q));
      mwm_pkg::OP_VISIT:   new_byte = ram_rdata | mwm_pkg::FLAG_VISITED;
      mwm_pkg::OP_CONFIRM: new_byte = ram_rdata | mwm_pkg::FLAG_CONFIRMED;
      mwm_pkg::OP_RAW:     new_byte = raw_q;
      default:             new_byte = ram_rdata;
    endcase
    nb_byte = wp_q ? (ram_rdata | mwm_pkg::facing_mask(dir_q))
                   : (ram_rdata & ~mwm_pkg::facing_mask(dir_q));
  end

  // a clear keeps the range flag taken at accept
  always_comb begin
    res_cell.in_range  = 1'b1;
    res_cell.dir       = dir_q;
    res_cell.cbyte     = new_byte;
    res_clear.in_range = res.in_range;
    res_clear.dir      = dir_q;
    res_clear.cbyte    = mwm_pkg::border_byte(8'(x_q), 8'(y_q), MAP_WIDTH, MAP_HEIGHT);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mwm_pkg::ST_CLEAR: begin
        if (clr_last) state_next = clr_result ? mwm_pkg::ST_DONE : mwm_pkg::ST_IDLE;
      end
      mwm_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.op == mwm_pkg::OP_CLEAR) state_next = mwm_pkg::ST_CLEAR;
          else if (!req_in_range)          state_next = mwm_pkg::ST_DONE;
          else                             state_next = mwm_pkg::ST_CELL;
        end
      end
      mwm_pkg::ST_CELL: begin
        if (op_q == mwm_pkg::OP_WALL && nb_ok) state_next = mwm_pkg::ST_NREAD;
        else if (out_free)                     state_next = mwm_pkg::ST_IDLE;
        else                                   state_next = mwm_pkg::ST_DONE;
      end
      mwm_pkg::ST_NREAD: state_next = mwm_pkg::ST_NWRITE;
      mwm_pkg::ST_NWRITE: begin
        state_next = out_free ? mwm_pkg::ST_IDLE : mwm_pkg::ST_DONE;
      end
      mwm_pkg::ST_DONE: begin
        if (out_free) state_next = mwm_pkg::ST_IDLE;
      end
      default: state_next = mwm_pkg::ST_IDLE;
    endcase
  end

  // outputs: memory port, handshake, result load
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {y_q, x_q};
    ram_wdata = new_byte;
    req.ready = 1'b0;
    load_out  = 1'b0;
    load_res  = res;
    case (state)
      mwm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = mwm_pkg::border_byte(8'(clr_cnt[XB-1:0]), 8'(clr_cnt[AW-1:XB]),
                                         MAP_WIDTH, MAP_HEIGHT);
      end
      mwm_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        ram_addr  = {req.cell_y[YB-1:0], req.cell_x[XB-1:0]};
      end
      mwm_pkg::ST_CELL: begin
        ram_we = (op_q == mwm_pkg::OP_WALL) || (op_q == mwm_pkg::OP_VISIT) ||
                 (op_q == mwm_pkg::OP_CONFIRM) || (op_q == mwm_pkg::OP_RAW);
        if (!(op_q == mwm_pkg::OP_WALL && nb_ok) && out_free) begin
          load_out = 1'b1;
          load_res = res_cell;
        end
      end
      mwm_pkg::ST_NREAD: begin
        ram_addr = {nb_y, nb_x};
      end
      mwm_pkg::ST_NWRITE: begin
        ram_we    = 1'b1;
        ram_addr  = {nb_y, nb_x};
        ram_wdata = nb_byte;
        load_out  = out_free;
      end
      mwm_pkg::ST_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mwm_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      clr_result <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mwm_pkg::ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (accept) clr_result <= (req.op == mwm_pkg::OP_CLEAR);
      if (load_out)       out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.op;
      x_q   <= req.cell_x[XB-1:0];
      y_q   <= req.cell_y[YB-1:0];
      dir_q <= req.direction;
      wp_q  <= req.wall_present;
      raw_q <= req.raw_byte;
      res.in_range <= req_in_range;
      res.dir      <= req.direction;
      res.cbyte    <= 8'h00;
    end else if (state == mwm_pkg::ST_CELL) begin
      res <= res_cell;
    end else if (state == mwm_pkg::ST_CLEAR && clr_last) begin
      res <= res_clear;
    end
    if (load_out) out_res <= load_res;
  end

  mwm_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rsp.valid = out_valid;

  mwm_result u_result (
    .res           (out_res),
    .cell_in_range (rsp.cell_in_range),
    .has_wall      (rsp.has_wall),
    .is_visited    (rsp.is_visited),
    .is_confirmed  (rsp.is_confirmed),
    .cell_byte     (rsp.cell_byte)
  );

endmodule

// ----- tb/tb_maze_wall_map_store_core.sv -----
`timescale 1ns / 1ps
module tb_maze_wall_map_store_core;

  localparam int MAP_W = mwm_pkg::MAP_WIDTH_DEF;
  localparam int MAP_H = mwm_pkg::MAP_HEIGHT_DEF;
  localparam int RANDOM_ITEMS = 1625;
  localparam int HOLD_CYCLES = 160;
  localparam int DRAIN_LIMIT = 5000;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] dir;
    logic       present;
    logic [7:0] raw;
  } req_t;

  typedef struct packed {
    logic       in_range;
    logic       wall;
    logic       visited;
    logic       confirmed;
    logic [7:0] cbyte;
  } rsp_t;

  typedef struct packed {
    req_t rq;
    logic known;
    rsp_t ex;
  } row_t;

  logic clk;
  logic rst;
  logic drv_known;
  rsp_t drv_exp;

  logic [7:0] cell_map [0:MAP_W*MAP_H-1];
  rsp_t expected_q [$];

  int errors;
  int n_req, n_wall, n_clear, n_outside, n_checked;

  mwm_in_if  request_ch ();
  mwm_out_if result_ch ();

  maze_wall_map_store_core dut (
    .clk (clk),
    .rst (rst),
    .req (request_ch.sink),
    .rsp (result_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] wall_bit(input logic [1:0] dir);
    case (dir)
      mwm_pkg::DIR_N: return mwm_pkg::WALL_N;
      mwm_pkg::DIR_E: return mwm_pkg::WALL_E;
      mwm_pkg::DIR_S: return mwm_pkg::WALL_S;
      default:        return mwm_pkg::WALL_W;
    endcase
  endfunction

  function automatic void reset_map();
    for (int yy = 0; yy < MAP_H; yy++) begin
      for (int xx = 0; xx < MAP_W; xx++) begin
        logic [7:0] b;
        b = 8'h00;
        if (yy == 0) b |= mwm_pkg::WALL_S;
        if (yy == MAP_H - 1) b |= mwm_pkg::WALL_N;
        if (xx == 0) b |= mwm_pkg::WALL_W;
        if (xx == MAP_W - 1) b |= mwm_pkg::WALL_E;
        cell_map[yy*MAP_W + xx] = b;
      end
    end
  endfunction

  function automatic void put_bit(input int xx, input int yy, input logic [7:0] mask,
                                  input logic set);
    if (set) cell_map[yy*MAP_W + xx] |= mask;
    else cell_map[yy*MAP_W + xx] &= ~mask;
  endfunction

  // advances the map by one request and returns the word it should produce
  function automatic rsp_t apply_request(input req_t q);
    rsp_t r;
    logic [7:0] b;
    logic [1:0] opp;
    bit ok, nb_ok;
    int xx, yy, nx, ny;
    xx = q.x;
    yy = q.y;
    ok = (xx < MAP_W) && (yy < MAP_H);
    if (q.op == mwm_pkg::OP_CLEAR) begin
      reset_map();
    end else if (ok) begin
      case (q.op)
        mwm_pkg::OP_WALL: begin
          put_bit(xx, yy, wall_bit(q.dir), q.present);
          nx = xx;
          ny = yy;
          case (q.dir)
            mwm_pkg::DIR_N: begin ny = yy + 1; nb_ok = ny < MAP_H; end
            mwm_pkg::DIR_E: begin nx = xx + 1; nb_ok = nx < MAP_W; end
            mwm_pkg::DIR_S: begin ny = yy - 1; nb_ok = yy > 0; end
            default:        begin nx = xx - 1; nb_ok = xx > 0; end
          endcase
          opp = q.dir + 2'd2;
          if (nb_ok) put_bit(nx, ny, wall_bit(opp), q.present);
        end
        mwm_pkg::OP_VISIT:   cell_map[yy*MAP_W + xx] |= mwm_pkg::FLAG_VISITED;
        mwm_pkg::OP_CONFIRM: cell_map[yy*MAP_W + xx] |= mwm_pkg::FLAG_CONFIRMED;
        mwm_pkg::OP_RAW:     cell_map[yy*MAP_W + xx] = q.raw;
        default: ;
      endcase
    end
    if (ok) begin
      b = cell_map[yy*MAP_W + xx];
      r.in_range = 1'b1;
      r.wall = |(b & wall_bit(q.dir));
      r.visited = b[mwm_pkg::VISITED_BIT];
      r.confirmed = b[mwm_pkg::CONFIRMED_BIT];
      r.cbyte = b;
    end else begin
      r = '{in_range: 1'b0, wall: 1'b1, visited: 1'b0, confirmed: 1'b0, cbyte: 8'h00};
    end
    return r;
  endfunction

  function automatic int draw_gap(input int mode);
    case (mode)
      0: return $urandom_range(0, 13);
      1: return 0;
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    endcase
  endfunction

  // mostly inside the map, biased toward the edges, now and then outside it
  function automatic logic [7:0] pick_coord(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'($urandom_range(lim, 255));
    if (r < 25) return ($urandom_range(0, 1) != 0) ? 8'(lim - 1) : 8'h00;
    return 8'($urandom_range(0, lim - 1));
  endfunction

  function automatic req_t rand_request();
    req_t q;
    int r;
    r = $urandom_range(0, 99);
    if (r < 1) q.op = mwm_pkg::OP_CLEAR;
    else if (r < 21) q.op = mwm_pkg::OP_QUERY;
    else if (r < 56) q.op = mwm_pkg::OP_WALL;
    else if (r < 66) q.op = mwm_pkg::OP_VISIT;
    else if (r < 76) q.op = mwm_pkg::OP_CONFIRM;
    else if (r < 91) q.op = mwm_pkg::OP_RAW;
    else if (r < 95) q.op = OP_SPARE6;
    else q.op = OP_SPARE7;
    q.x = pick_coord(MAP_W);
    q.y = pick_coord(MAP_H);
    q.dir = 2'($urandom_range(0, 3));
    q.present = 1'($urandom_range(0, 1));
    q.raw = 8'($urandom_range(0, 255));
    return q;
  endfunction

  function automatic row_t mk(input logic [2:0] op, input int xx, input int yy,
                              input logic [1:0] dir, input logic present, input int raw,
                              input logic known, input logic in_range, input logic wall,
                              input logic visited, input logic confirmed, input int cbyte);
    row_t t;
    t.rq = '{op: op, x: xx[7:0], y: yy[7:0], dir: dir, present: present, raw: raw[7:0]};
    t.known = known;
    t.ex = '{in_range: in_range, wall: wall, visited: visited, confirmed: confirmed,
             cbyte: cbyte[7:0]};
    return t;
  endfunction

  task automatic send_request(input req_t q, input logic known, input rsp_t e, input int gap);
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid        <= 1'b1;
    request_ch.op           <= q.op;
    request_ch.cell_x       <= q.x;
    request_ch.cell_y       <= q.y;
    request_ch.direction    <= q.dir;
    request_ch.wall_present <= q.present;
    request_ch.raw_byte     <= q.raw;
    drv_known               <= known;
    drv_exp                 <= e;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : request_monitor
    req_t q;
    rsp_t p;
    if (!rst && request_ch.valid && request_ch.ready) begin
      q.op = request_ch.op;
      q.x = request_ch.cell_x;
      q.y = request_ch.cell_y;
      q.dir = request_ch.direction;
      q.present = request_ch.wall_present;
      q.raw = request_ch.raw_byte;
      p = apply_request(q);
      expected_q.push_back(drv_known ? drv_exp : p);
      n_req++;
      if (q.op == mwm_pkg::OP_WALL) n_wall++;
      if (q.op == mwm_pkg::OP_CLEAR) n_clear++;
      if (q.x >= MAP_W || q.y >= MAP_H) n_outside++;
    end
  end

  always @(posedge clk) begin : result_monitor
    rsp_t e;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with no request pending");
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("cell_in_range", e.in_range, result_ch.cell_in_range);
        check_field("has_wall", e.wall, result_ch.has_wall);
        check_field("is_visited", e.visited, result_ch.is_visited);
        check_field("is_confirmed", e.confirmed, result_ch.is_confirmed);
        check_field("cell_byte", e.cbyte, result_ch.cell_byte);
        n_checked++;
      end
    end
  end

  initial begin : result_sink
    int gap;
    int taken;
    int mode;
    taken = 0;
    mode = 0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 150 == 0) mode = $urandom_range(0, 2);
      // long hold-offs let the block back up into its request side
      if (taken == 400 || taken == 1200) gap = HOLD_CYCLES;
      else gap = draw_gap(mode);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : main_seq
    row_t directed_plan [0:24];
    rsp_t none;
    int mode;
    int waited;
    errors = 0;
    n_req = 0;
    n_wall = 0;
    n_clear = 0;
    n_outside = 0;
    n_checked = 0;
    none = '0;
    rst = 1'b1;
    request_ch.valid        <= 1'b0;
    request_ch.op           <= mwm_pkg::OP_QUERY;
    request_ch.cell_x       <= 8'h00;
    request_ch.cell_y       <= 8'h00;
    request_ch.direction    <= mwm_pkg::DIR_N;
    request_ch.wall_present <= 1'b0;
    request_ch.raw_byte     <= 8'h00;
    drv_known               <= 1'b0;
    drv_exp                 <= '0;
    reset_map();

    directed_plan = '{
      mk(mwm_pkg::OP_QUERY, 0, 0, mwm_pkg::DIR_S, 1'b0, 8'h00,
         1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h0C),
      mk(mwm_pkg::OP_QUERY, 15, 15, mwm_pkg::DIR_N, 1'b0, 8'h00,
         1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h03),
      mk(mwm_pkg::OP_QUERY, 255, 255, mwm_pkg::DIR_N, 1'b0, 8'h00,
         1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_QUERY, 16, 0, mwm_pkg::DIR_E, 1'b0, 8'h00,
         1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_QUERY, 0, 16, mwm_pkg::DIR_W, 1'b0, 8'h00,
         1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_WALL, 5, 5, mwm_pkg::DIR_N, 1'b1, 8'h00,
         1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h01),
      mk(mwm_pkg::OP_QUERY, 5, 6, mwm_pkg::DIR_S, 1'b0, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_WALL, 0, 3, mwm_pkg::DIR_W, 1'b0, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_WALL, 15, 3, mwm_pkg::DIR_E, 1'b1, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_WALL, 7, 0, mwm_pkg::DIR_S, 1'b0, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_WALL, 7, 15, mwm_pkg::DIR_N, 1'b1, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_WALL, 3, 3, mwm_pkg::DIR_E, 1'b1, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_WALL, 4, 3, mwm_pkg::DIR_W, 1'b0, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_VISIT, 2, 2, mwm_pkg::DIR_N, 1'b0, 8'h00,
         1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h10),
      mk(mwm_pkg::OP_CONFIRM, 2, 2, mwm_pkg::DIR_N, 1'b0, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_RAW, 9, 9, mwm_pkg::DIR_W, 1'b0, 8'hFF,
         1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF),
      mk(mwm_pkg::OP_RAW, 0, 0, mwm_pkg::DIR_S, 1'b1, 8'h00,
         1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_RAW, 255, 0, mwm_pkg::DIR_N, 1'b0, 8'hAA,
         1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_WALL, 200, 3, mwm_pkg::DIR_N, 1'b1, 8'h00,
         1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_VISIT, 3, 255, mwm_pkg::DIR_E, 1'b0, 8'h00,
         1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00),
      mk(OP_SPARE6, 9, 9, mwm_pkg::DIR_E, 1'b1, 8'h55,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(OP_SPARE7, 0, 0, mwm_pkg::DIR_N, 1'b1, 8'h55,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_CLEAR, 255, 255, mwm_pkg::DIR_N, 1'b0, 8'h00,
         1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_QUERY, 9, 9, mwm_pkg::DIR_N, 1'b0, 8'h00,
         1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
      mk(mwm_pkg::OP_CLEAR, 0, 15, mwm_pkg::DIR_W, 1'b0, 8'h00,
         1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h09)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i])
      send_request(directed_plan[i].rq, directed_plan[i].known, directed_plan[i].ex,
                   draw_gap(0));

    mode = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) mode = $urandom_range(0, 2);
      send_request(rand_request(), 1'b0, none, draw_gap(mode));
    end
    request_ch.valid <= 1'b0;

    waited = 0;
    while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_q.size() != 0) begin
      $error("%0d result words never arrived", expected_q.size());
      errors++;
    end
    repeat (16) @(posedge clk);

    $display("covered %0d requests: %0d wall writes, %0d map clears, %0d outside the map",
             n_req, n_wall, n_clear, n_outside);
    $display("%0d result words checked field by field, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
